@@ sv/mbl_pkg.sv @@
// ----------------------------------------------------------------------------
// mbl_pkg
// shared types, constants and the code-bit table of the node evaluator
// ----------------------------------------------------------------------------
package mbl_pkg;

  localparam int CORNER_W      = 32;
  localparam int NUM_CORNERS   = 16;
  localparam int NUM_BLOCKS    = 9;
  localparam int CENTRE_BLOCK  = 4;
  localparam int GRID_COLS     = 3;
  localparam int CORNER_COLS   = 4;
  localparam int CODE_SIGN_BIT = 31;
  localparam int CODE_W        = 8;
  localparam int MAP_W         = 256;
  localparam int IN_DATA_W     = 768;
  localparam int OUT_DATA_W    = 16;
  localparam int MAP_LSB       = NUM_CORNERS * CORNER_W;

  typedef logic [CORNER_W-1:0]               word_t;
  typedef logic [NUM_BLOCKS-1:0][CORNER_W-1:0] block_sums_t;
  typedef logic [CODE_W-1:0]                 code_t;
  typedef logic [MAP_W-1:0]                  code_map_t;

  // pipeline load strobes handed to the merge stage
  typedef struct packed {
    logic load_code;
    logic load_out;
  } mbl_ctrl_t;

  // code bit driven by each block, centre block has none
  function automatic logic [2:0] code_bit(input int blk);
    logic [2:0] pos;
    case (blk)
      0:       pos = 3'd7;
      1:       pos = 3'd6;
      2:       pos = 3'd5;
      3:       pos = 3'd0;
      5:       pos = 3'd4;
      6:       pos = 3'd1;
      7:       pos = 3'd2;
      8:       pos = 3'd3;
      default: pos = 3'd0;
    endcase
    return pos;
  endfunction

endpackage

@@ sv/mb_lbp_node_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// mb_lbp_node_evaluator_top
// multi-block lbp tree node evaluator, one node per transaction
// ----------------------------------------------------------------------------
// Each input transaction carries the sixteen integral-image corners of a 3x3
// block grid and the node's 256-bit code map; each output transaction carries
// the 8-bit pattern code and the first-child flag. The block takes one
// transaction every clock cycle unless the output stalls, and returns its
// result through three register stages: nine block-sum lanes, the merge
// into the pattern code, and the code-map bit lookup into the output register.
// Every stage has its own valid bit and a stage loads whenever it is empty or
// its successor moves, so a stalled output only backs up as far as it must.
module mb_lbp_node_evaluator_top (
  input  logic                             clk,
  input  logic                             rst,
  // corner_pair_0..7 [511:0], code_map_0..3 [767:512]
  input  logic [mbl_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pattern_code [7:0], take_first_child [8], zero [15:9]
  output logic [mbl_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready
);
  import mbl_pkg::*;

  // stage valids: sums, code, output
  logic        sum_valid;
  logic        code_valid;
  logic        sum_ready;
  logic        code_ready;
  logic        out_ready;
  mbl_ctrl_t   ctrl;
  block_sums_t sums;
  code_map_t   map_s1;
  code_t       pattern_code;
  logic        take_first_child;

  // per-stage ready chain
  assign out_ready  = !m_tvalid || m_tready;
  assign code_ready = !code_valid || out_ready;
  assign sum_ready  = !sum_valid || code_ready;
  assign s_tready   = sum_ready;

  assign ctrl.load_code = code_ready;
  assign ctrl.load_out  = out_ready;

  // one lane per 3x3 block, corner i sits at s_tdata[32*i +: 32]
  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_lane
    localparam int TL = CORNER_COLS * (k / GRID_COLS) + (k % GRID_COLS);
    localparam int BL = TL + CORNER_COLS;
    mbl_lane u_lane (
      .clk  (clk),
      .load (sum_ready),
      .tl   (s_tdata[CORNER_W*TL +: CORNER_W]),
      .tr   (s_tdata[CORNER_W*(TL+1) +: CORNER_W]),
      .bl   (s_tdata[CORNER_W*BL +: CORNER_W]),
      .br   (s_tdata[CORNER_W*(BL+1) +: CORNER_W]),
      .sum  (sums[k])
    );
  end

  // code map travels alongside the lane sums
  always_ff @(posedge clk) begin
    if (sum_ready) begin
      map_s1 <= s_tdata[MAP_LSB +: MAP_W];
    end
  end

  mbl_merge u_merge (
    .clk              (clk),
    .ctrl             (ctrl),
    .sums             (sums),
    .code_map         (map_s1),
    .pattern_code     (pattern_code),
    .take_first_child (take_first_child)
  );

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      code_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid <= s_tvalid;
      end
      if (code_ready) begin
        code_valid <= sum_valid;
      end
      if (out_ready) begin
        m_tvalid <= code_valid;
      end
    end
  end

  assign m_tdata = {{(OUT_DATA_W-CODE_W-1){1'b0}}, take_first_child, pattern_code};

`ifndef SYNTHESIS
  // accepted transaction lands in the lane stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> sum_valid)
    else $error("accepted transaction missing from lane stage");

  // a blocked lane stage keeps its transaction
  a_sum_held: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !code_ready |=> sum_valid)
    else $error("lane stage dropped a transaction");

  // a code waiting over an empty output register moves on
  a_code_moves: assert property (@(posedge clk) disable iff (rst)
    code_valid && !m_tvalid |=> m_tvalid)
    else $error("code stage failed to advance");

  // empty output register never blocks input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");
`endif

endmodule

@@ sv/mbl_lane.sv @@
// ----------------------------------------------------------------------------
// mbl_lane
// one block lane: block sum from four integral-image corners, registered
// ----------------------------------------------------------------------------
module mbl_lane (
  input  logic          clk,
  input  logic          load,
  input  mbl_pkg::word_t tl,
  input  mbl_pkg::word_t tr,
  input  mbl_pkg::word_t bl,
  input  mbl_pkg::word_t br,
  output mbl_pkg::word_t sum
);
  import mbl_pkg::*;

  // wrapping 32-bit area sum
  always_ff @(posedge clk) begin
    if (load) begin
      sum <= tl - tr - bl + br;
    end
  end

endmodule

@@ sv/mbl_merge.sv @@
// ----------------------------------------------------------------------------
// mbl_merge
// merges lane sums into the pattern code, then looks up the code map bit
// ----------------------------------------------------------------------------
module mbl_merge (
  input  logic                   clk,
  input  mbl_pkg::mbl_ctrl_t     ctrl,
  input  mbl_pkg::block_sums_t   sums,
  input  mbl_pkg::code_map_t     code_map,
  output mbl_pkg::code_t         pattern_code,
  output logic                   take_first_child
);
  import mbl_pkg::*;

  code_t     code_comb;
  code_t     code_q;
  code_map_t map_q;
  word_t     diff [NUM_BLOCKS];

  // outer block minus centre, sign clear sets the code bit
  always_comb begin
    code_comb = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      diff[k] = sums[k] - sums[CENTRE_BLOCK];
      if (k != CENTRE_BLOCK) begin
        code_comb[code_bit(k)] = ~diff[k][CODE_SIGN_BIT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_code) begin
      code_q <= code_comb;
      map_q  <= code_map;
    end
    if (ctrl.load_out) begin
      pattern_code     <= code_q;
      take_first_child <= map_q[code_q];
    end
  end

endmodule

@@ tb/mb_lbp_node_evaluator_top_tb.sv @@
// ----------------------------------------------------------------------------
// mb_lbp_node_evaluator_top_tb
// self-checking testbench for the multi-block lbp node evaluator
// ----------------------------------------------------------------------------
// A short list of directed nodes (flat grids, a single set corner, wrapping
// sums, map extremes) is followed by random nodes: mostly well-formed integral
// images with small block sums, so equal and near-equal blocks are common, and
// some fully random words. Each taken node queues a verdict, typed for known
// rows, else eval_node's; every output transaction is compared with the oldest
// queued verdict. Both sides idle at random, the output side holds off for a
// long stretch once, and the sender once waits for the pipeline to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mb_lbp_node_evaluator_top_tb;
  import mbl_pkg::*;

  localparam int PHASE_NODES = 125;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // code bit set by each block of the grid, the centre block sets none
  localparam int LBP_BIT_OF [NUM_BLOCKS] = '{7, 6, 5, 0, 0, 4, 1, 2, 3};

  localparam code_map_t MAP_NONE = '0;
  localparam code_map_t MAP_ALL = '1;
  localparam code_map_t MAP_TOP = code_map_t'(1) << 255;
  localparam code_map_t MAP_128 = code_map_t'(1) << 128;
  localparam code_map_t MAP_ALT = {64{4'hA}};
  localparam code_map_t MAP_MIX = {8{32'h0F0F_3C3C}};

  typedef struct packed {
    code_t code;
    logic  take;
  } node_verdict_t;

  // directed row: every corner gets fill, one corner may be overwritten
  typedef struct packed {
    word_t     fill;
    logic      poke_en;
    logic [3:0] poke_idx;
    word_t     poke_val;
    code_map_t map;
    logic      known;
    code_t     code;
    logic      take;
  } node_row_t;

  localparam int NUM_ROWS = 23;
  localparam node_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // flat grids: every difference is zero, so every code bit is set
    '{32'h0, 1'b0, 4'd0, 32'h0, MAP_NONE, 1'b1, 8'hFF, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 4'd0, 32'h0, MAP_ALL, 1'b1, 8'hFF, 1'b1},
    '{32'h0, 1'b0, 4'd0, 32'h0, MAP_TOP, 1'b1, 8'hFF, 1'b1},
    // a single unit at the centre's top-left corner leaves only b0 level
    '{32'h0, 1'b1, 4'd5, 32'h1, MAP_128, 1'b1, 8'h80, 1'b1},
    '{32'h0, 1'b1, 4'd5, 32'h1, ~MAP_128, 1'b1, 8'h80, 1'b0},
    // sums that overflow a signed 32-bit word
    '{32'h0, 1'b1, 4'd5, 32'h8000_0000, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 4'd10, 32'h8000_0000, MAP_ALT, 1'b0, 8'h0, 1'b0},
    // each corner on its own at all ones
    '{32'h0, 1'b1, 4'd0, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd1, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd2, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd3, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd4, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd5, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd6, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd7, 32'hFFFF_FFFF, MAP_ALT, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd8, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd9, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd10, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd11, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd12, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd13, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd14, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0},
    '{32'h0, 1'b1, 4'd15, 32'hFFFF_FFFF, MAP_MIX, 1'b0, 8'h0, 1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;

  node_verdict_t pending_verdicts [$];
  int            mismatch_cnt;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            hold_req;
  int            hold_left;
  int            quiet_cycles;

  mb_lbp_node_evaluator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // block sums of the 3x3 grid, differences against the centre, map lookup
  function automatic node_verdict_t eval_node(input logic [IN_DATA_W-1:0] din);
    word_t         corner [NUM_CORNERS];
    word_t         sums [NUM_BLOCKS];
    word_t         diff;
    int            tl;
    node_verdict_t v;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      corner[k] = din[k*CORNER_W +: CORNER_W];
    end
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      tl = CORNER_COLS * (b / GRID_COLS) + (b % GRID_COLS);
      sums[b] = corner[tl] - corner[tl+1] - corner[tl+CORNER_COLS]
                + corner[tl+CORNER_COLS+1];
    end
    v.code = '0;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (b != CENTRE_BLOCK) begin
        diff = sums[b] - sums[CENTRE_BLOCK];
        if (!diff[CODE_SIGN_BIT]) begin
          v.code[LBP_BIT_OF[b]] = 1'b1;
        end
      end
    end
    v.take = din[MAP_LSB + v.code];
    return v;
  endfunction

  // integral image of a random grid plus row and column offsets, which cancel
  // in every block sum; narrow block values make ties with the centre common
  function automatic logic [IN_DATA_W-1:0] make_grid(input bit wide);
    word_t                blk [NUM_BLOCKS];
    word_t                row_off [CORNER_COLS];
    word_t                col_off [CORNER_COLS];
    word_t                base;
    word_t                acc;
    logic [IN_DATA_W-1:0] din;
    base = $urandom;
    for (int i = 0; i < CORNER_COLS; i++) begin
      row_off[i] = $urandom;
      col_off[i] = $urandom;
    end
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      blk[b] = wide ? $urandom : $urandom_range(0, 3);
    end
    for (int r = 0; r < CORNER_COLS; r++) begin
      for (int c = 0; c < CORNER_COLS; c++) begin
        acc = base + row_off[r] + col_off[c];
        for (int i = 0; i < r; i++) begin
          for (int j = 0; j < c; j++) begin
            acc = acc + blk[GRID_COLS*i + j];
          end
        end
        din[(CORNER_COLS*r + c)*CORNER_W +: CORNER_W] = acc;
      end
    end
    for (int k = 0; k < MAP_W / 32; k++) begin
      din[MAP_LSB + 32*k +: 32] = $urandom;
    end
    return din;
  endfunction

  // offer one node, queue its verdict once the input transaction is taken
  task automatic send_node(input logic [IN_DATA_W-1:0] din, input bit known,
                           input node_verdict_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= din;
    do @(posedge clk); while (!s_tready);
    pending_verdicts.push_back(known ? typed : eval_node(din));
  endtask

  task automatic run_random(input int count, input bit pressure);
    logic [IN_DATA_W-1:0] din;
    int                   pick;
    for (int n = 0; n < count; n++) begin
      if (pressure && n == 20) begin
        hold_req = 1'b1;
      end
      if (pressure && n == 60) begin
        // let everything in flight come out before going on
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        din = make_grid(1'b0);
      end else if (pick < 75) begin
        din = make_grid(1'b1);
      end else begin
        for (int k = 0; k < IN_DATA_W / 32; k++) begin
          din[32*k +: 32] = $urandom;
        end
      end
      send_node(din, 1'b0, '0);
    end
  endtask

  // output side: random back-pressure, or a long hold when asked for
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each output transaction with the oldest queued verdict
  always @(posedge clk) begin
    node_verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result code=%h take=%b", $time, m_tdata[7:0],
                 m_tdata[8]);
        mismatch_cnt++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[7:0] !== want.code) begin
          $display("%0t: pattern_code expected %h actual %h", $time, want.code,
                   m_tdata[7:0]);
          mismatch_cnt++;
        end
        if (m_tdata[8] !== want.take) begin
          $display("%0t: take_first_child expected %b actual %b", $time,
                   want.take, m_tdata[8]);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [IN_DATA_W-1:0] din;
    node_verdict_t        typed;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    mismatch_cnt  = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 8;
    recv_idle_pct = 46;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        din[k*CORNER_W +: CORNER_W] = DIRECTED_ROWS[i].fill;
      end
      if (DIRECTED_ROWS[i].poke_en) begin
        din[DIRECTED_ROWS[i].poke_idx*CORNER_W +: CORNER_W] = DIRECTED_ROWS[i].poke_val;
      end
      din[MAP_LSB +: MAP_W] = DIRECTED_ROWS[i].map;
      typed.code = DIRECTED_ROWS[i].code;
      typed.take = DIRECTED_ROWS[i].take;
      send_node(din, DIRECTED_ROWS[i].known, typed);
    end

    run_random(PHASE_NODES, 1'b1);
    send_idle_pct = 46;
    recv_idle_pct = 8;
    run_random(PHASE_NODES, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_NODES, 1'b0);

    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ mb_lbp_node_evaluator_top.f @@
sv/mbl_pkg.sv
sv/mbl_lane.sv
sv/mbl_merge.sv
sv/mb_lbp_node_evaluator_top.sv
tb/mb_lbp_node_evaluator_top_tb.sv
